FILE: hdl/apv_zero_suppressed_word_parser_macros.svh
// Assertion macros shared by the parser modules.
`ifndef APV_ZERO_SUPPRESSED_WORD_PARSER_MACROS_SVH
`define APV_ZERO_SUPPRESSED_WORD_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define APV_ZS_CHECK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apv_zs: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define APV_ZS_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apv_zs: next-cycle check failed");

`endif

FILE: hdl/apv_zs_pkg.sv
`timescale 1ns / 1ps

package apv_zs_pkg;

   localparam logic [31:0] END_WORD          = 32'hfafa_fafa;
   localparam logic [23:0] EVENT_HEADER_TAG  = 24'h41_505a;
   localparam logic [31:0] EQUIP_HEADER_WORD = 32'hda1e_5afe;
   localparam logic [31:0] EQUIP_START_WORD  = 32'h0000_0050;
   localparam logic [8:0]  HALF_INDEX_MAX    = 9'd511;
   localparam logic [8:0]  FIRST_DATA_HALF   = 9'd4;
   localparam logic [1:0]  EWC_SKIP          = 2'd2;
   localparam logic [1:0]  EWC_DATA          = 2'd3;
   localparam logic [12:0] STRIP_LIMIT       = 13'd127;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_END    = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               plane;
      logic [7:0]         strip;
      logic [7:0]         time_bin;
      logic signed [16:0] adc_value;
      logic               last_of_strip;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } slot_type;

   // one queue entry: up to two results caused by one word
   typedef struct packed {
      slot_type s1;
      slot_type s0;
   } pair_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Sample result for one half; valid only when the channel maps to a strip
   // and the chip id is one of the four chips.
   function automatic slot_type sample_slot(logic [15:0] half, logic [7:0] pos,
                                            logic [7:0] tbins, logic [15:0] chan,
                                            logic [7:0] chip);
      logic [12:0] lin;
      logic [16:0] neg;
      slot_type    s;
      // 32*(c&3) + 8*(c>>2) - 31*(c>>4) reduces to 32*c[1:0] + 8*c[3:2] + c[15:4]
      lin = {6'd0, chan[1:0], 5'd0} + {8'd0, chan[3:2], 3'd0} + {1'b0, chan[15:4]};
      neg = 17'd0 - {1'b0, half};
      if (half[15:11] != 5'd0) begin
         neg = neg + 17'h10000;
      end
      s.valid             = (lin <= STRIP_LIMIT) && (chip[7:2] == 6'd0);
      s.res.kind          = KIND_SAMPLE;
      s.res.plane         = chip[1];
      s.res.strip         = {chip[0], lin[6:0]};
      s.res.time_bin      = pos - 8'd1;
      s.res.adc_value     = $signed(neg);
      s.res.last_of_strip = (pos >= tbins);
      return s;
   endfunction

endpackage

FILE: hdl/apv_zs_front.sv
`timescale 1ns / 1ps

module apv_zs_front import apv_zs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  qstat_type   qstat,
   output logic        push,
   output pair_type    push_entry
);

   logic [31:0] prev_ff,     prev_in;
   logic        in_event_ff, in_event_in;
   logic [1:0]  ewc_ff,      ewc_in;
   logic [8:0]  half_ff,     half_in;
   logic [7:0]  gpos_ff,     gpos_in;
   logic [7:0]  tbins_ff,    tbins_in;
   logic [15:0] chan_ff,     chan_in;
   logic [7:0]  chip_ff,     chip_in;
   pair_type    pair;
   slot_type    smp0, smp1;
   logic        accept;
   logic        hdr_p, end_p, equip, hdr_w;
   logic [15:0] h0, h1;
   logic        last0, last1;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   assign hdr_p = (prev_ff[31:8] == EVENT_HEADER_TAG);
   assign end_p = (prev_ff == END_WORD);
   assign equip = (prev_ff == EQUIP_HEADER_WORD) && (req_tdata == EQUIP_START_WORD);
   assign hdr_w = (req_tdata[31:8] == EVENT_HEADER_TAG);
   // byte-swapped halves of the previous word
   assign h0    = {prev_ff[23:16], prev_ff[31:24]};
   assign h1    = {prev_ff[7:0], prev_ff[15:8]};

   always_comb begin
      prev_in     = prev_ff;
      in_event_in = in_event_ff;
      ewc_in      = ewc_ff;
      half_in     = half_ff;
      gpos_in     = gpos_ff;
      tbins_in    = tbins_ff;
      chan_in     = chan_ff;
      chip_in     = chip_ff;
      pair        = '0;
      smp0        = '0;
      smp1        = '0;
      last0       = 1'b0;
      last1       = 1'b0;
      if (accept) begin
         prev_in = req_tdata;
         if (hdr_p) begin
            chip_in     = prev_ff[7:0];
            tbins_in    = 8'd0;
            in_event_in = 1'b1;
            ewc_in      = 2'd0;
            chan_in     = 16'd0;
         end else if (end_p) begin
            pair.s0.valid    = 1'b1;
            pair.s0.res.kind = KIND_END;
            in_event_in      = 1'b0;
         end else if (equip) begin
            in_event_in = 1'b0;
         end
         if (!end_p) begin
            if (hdr_w) begin
               in_event_in = 1'b0;
            end
            if (in_event_in) begin
               if (ewc_in != EWC_DATA) begin
                  ewc_in = ewc_in + 2'd1;
               end
               if (ewc_in == EWC_SKIP) begin
                  half_in = 9'd0;
                  gpos_in = 8'd0;
               end else if (ewc_in == EWC_DATA) begin
                  if (half_in == 9'd0) begin
                     tbins_in = prev_ff[7:0];
                  end
                  // first half
                  if (half_in >= FIRST_DATA_HALF) begin
                     last0 = (gpos_in >= tbins_in);
                     if (gpos_in == 8'd0) begin
                        chan_in = h0;
                     end else begin
                        smp0    = sample_slot(h0, gpos_in, tbins_in, chan_in, chip_in);
                        pair.s0 = smp0;
                     end
                     gpos_in = last0 ? 8'd0 : gpos_in + 8'd1;
                  end
                  if (half_in != HALF_INDEX_MAX) begin
                     half_in = half_in + 9'd1;
                  end
                  // second half
                  if (half_in >= FIRST_DATA_HALF) begin
                     last1 = (gpos_in >= tbins_in);
                     if (gpos_in == 8'd0) begin
                        chan_in = h1;
                     end else begin
                        smp1    = sample_slot(h1, gpos_in, tbins_in, chan_in, chip_in);
                        pair.s1 = smp1;
                     end
                     gpos_in = last1 ? 8'd0 : gpos_in + 8'd1;
                  end
                  if (half_in != HALF_INDEX_MAX) begin
                     half_in = half_in + 9'd1;
                  end
               end
            end
         end
      end
   end

   assign push       = accept && (pair.s0.valid || pair.s1.valid);
   assign push_entry = pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         in_event_ff <= 1'b0;
         ewc_ff      <= '0;
         half_ff     <= '0;
         gpos_ff     <= '0;
         tbins_ff    <= '0;
         chan_ff     <= '0;
         chip_ff     <= '0;
      end else begin
         prev_ff     <= prev_in;
         in_event_ff <= in_event_in;
         ewc_ff      <= ewc_in;
         half_ff     <= half_in;
         gpos_ff     <= gpos_in;
         tbins_ff    <= tbins_in;
         chan_ff     <= chan_in;
         chip_ff     <= chip_in;
      end
   end

endmodule

FILE: hdl/apv_zs_queue.sv
`timescale 1ns / 1ps
`include "apv_zero_suppressed_word_parser_macros.svh"

module apv_zs_queue import apv_zs_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  pair_type  push_entry,
   input  logic      pop,
   output pair_type  head,
   output qstat_type stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   pair_type               mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff,  count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FULL_CNT);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `APV_ZS_CHECK_SAME(q_no_overflow, clock, reset, push, !stat.full || pop)
   `APV_ZS_CHECK_SAME(q_no_underflow, clock, reset, pop, !stat.empty)
   `APV_ZS_CHECK_NEXT(q_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: hdl/apv_zs_back.sv
`timescale 1ns / 1ps
`include "apv_zero_suppressed_word_parser_macros.svh"

module apv_zs_back import apv_zs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  pair_type   head,
   input  qstat_type  qstat,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_res
);

   result_type out_ff,        out_in;
   logic       out_valid_ff,  out_valid_in;
   result_type pend_ff,       pend_in;
   logic       pend_valid_ff, pend_valid_in;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_tready;
   // the second result of a pair is parked in pend_ff and goes out next
   assign pop      = out_free && !pend_valid_ff && !qstat.empty;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (!qstat.empty) begin
            out_valid_in = 1'b1;
            if (head.s0.valid) begin
               out_in        = head.s0.res;
               pend_in       = head.s1.res;
               pend_valid_in = head.s1.valid;
            end else begin
               out_in = head.s1.res;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_res    = out_ff;

   `APV_ZS_CHECK_SAME(b_pend_behind_out, clock, reset, pend_valid_ff, out_valid_ff)
   `APV_ZS_CHECK_NEXT(b_pop_fills_out, clock, reset, pop, out_valid_ff)
   `APV_ZS_CHECK_NEXT(b_out_hold, clock, reset, out_valid_ff && !rsp_tready, out_valid_ff && $stable(out_ff))

endmodule

FILE: hdl/apv_zero_suppressed_word_parser.sv
`timescale 1ns / 1ps
// Zero-suppressed readout word parser. One raw 32-bit word is taken per clock
// while the queue is not full and judged against the word before it; each word
// yields no result, one, or two (an end-of-event marker, or one ADC sample per
// data half). The front stage classifies the word and pushes its results into a
// QUEUE_DEPTH-entry queue; the back stage sends one result per clock, while
// rsp_tready allows, through an output register, so the two samples of a word
// leave one after the other and a stream of such words is held back by the full
// queue. Words with zero or one result sustain one word per clock when the port
// is not stalled. Each result word carries plane, strip, time bin, the negated
// 17-bit ADC value, the last-time-bin flag on tlast, and sample/end kind on tuser.

module apv_zero_suppressed_word_parser import apv_zs_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] word_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] plane, [8:1] strip, [16:9] time_bin,
                                    // [33:17] adc_value, [39:34] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // last_of_strip
);

   qstat_type  qstat;
   logic       push, pop;
   pair_type   push_entry, head;
   result_type res;

   apv_zs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   apv_zs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   apv_zs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (res)
   );

   assign rsp_tdata = {6'd0, res.adc_value, res.time_bin, res.strip, res.plane};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last_of_strip;

endmodule
